/* rtl/core/connection_id_hash_table_assert.svh */
// assertion macros for the connection id hash table
// used by connection_id_hash_table.sv, which supplies clk_i and rst_ni
`ifndef CONNECTION_ID_HASH_TABLE_ASSERT_SVH
`define CONNECTION_ID_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define CIDH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CIDH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cidh_pkg.sv */
// shared types, codes and hash constants for the connection id hash table
// no dependencies
`default_nettype none

package cidh_pkg;

  localparam int KEY_BYTES_MAX = 20;
  localparam int VALUE_W       = 16;
  localparam int HOME_BITS     = 16;
  localparam int KEY_MEM_W     = 5 + 32 + 64 + 64;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // fnv-1a style 64-bit hash with a nonstandard offset; prime is 2^40 + 435
  localparam logic [63:0] FNV_OFFSET    = 64'd1469598103934665603;
  localparam int          FNV_PRIME_SH  = 40;
  localparam logic [63:0] FNV_PRIME_LOW = 64'd435;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [31:0] key_word2;
    logic [4:0]  key_length;
    logic [15:0] value_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value_out;
    logic [9:0]  slot_index;
  } rsp_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [63:0]          key0;
    logic [63:0]          key1;
    logic [31:0]          key2;
    logic [4:0]           len;
    logic [VALUE_W-1:0]   handle;
    logic [HOME_BITS-1:0] home;
    logic                 bad;
  } job_t;

  // ones in the low n bytes of a 64-bit word
  function automatic logic [63:0] byte_mask64(input logic [4:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = {8{5'(i) < n}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cidh_front.sv */
// front end: takes requests, checks length, masks key bytes, hashes one byte a cycle
// depends on cidh_pkg
`default_nettype none

module cidh_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire cidh_pkg::req_t in_req_i,
  input  wire logic          hold_i,
  input  wire logic          full_i,
  output logic               push_o,
  output cidh_pkg::job_t     job_o
);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_e;

  fstate_e          state_q;
  cidh_pkg::job_t   job_q;
  logic [63:0]      h_q;
  logic [4:0]       idx_q;
  logic [19:0][7:0] kbytes;
  logic [63:0]      hx;
  logic [4:0]       len_in;
  logic             bad_in;

  assign kbytes = {job_q.key2, job_q.key1, job_q.key0};
  assign hx     = h_q ^ {56'd0, kbytes[idx_q]};
  assign len_in = in_req_i.key_length;
  assign bad_in = (len_in == 5'd0) || (len_in > 5'(cidh_pkg::KEY_BYTES_MAX));

  assign in_stall_o = (state_q != F_IDLE) || hold_i;
  assign push_o     = (state_q == F_PUSH) && !full_i;

  always_comb begin
    job_o      = job_q;
    job_o.home = h_q[cidh_pkg::HOME_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      job_q   <= '0;
      h_q     <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            job_q.mode   <= in_req_i.mode;
            job_q.key0   <= in_req_i.key_word0 & cidh_pkg::byte_mask64(len_in);
            job_q.key1   <= in_req_i.key_word1 &
                            cidh_pkg::byte_mask64(len_in > 5'd8 ? len_in - 5'd8 : 5'd0);
            job_q.key2   <= in_req_i.key_word2 & 32'(
                            cidh_pkg::byte_mask64(len_in > 5'd16 ? len_in - 5'd16 : 5'd0));
            job_q.len    <= len_in;
            job_q.handle <= in_req_i.value_handle;
            job_q.home   <= '0;
            job_q.bad    <= bad_in;
            h_q          <= cidh_pkg::FNV_OFFSET;
            idx_q        <= 5'd0;
            state_q      <= bad_in ? F_PUSH : F_HASH;
          end
        end
        F_HASH: begin
          h_q   <= (hx << cidh_pkg::FNV_PRIME_SH) + 64'(hx * cidh_pkg::FNV_PRIME_LOW);
          idx_q <= idx_q + 5'd1;
          if (idx_q == job_q.len - 5'd1) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cidh_queue.sv */
// two-entry queue of hashed jobs between front and back end
// depends on cidh_pkg
`default_nettype none

module cidh_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cidh_pkg::job_t job_i,
  input  wire logic           pop_i,
  output cidh_pkg::job_t      head_o,
  output logic                full_o,
  output logic                empty_o
);

  cidh_pkg::job_t ent_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cidh_back.sv */
// back end: clears flags after reset, probes the table, applies insert/lookup/delete
// depends on cidh_pkg
`default_nettype none

module cidh_back #(
  parameter int TABLE_SLOTS = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cidh_pkg::job_t job_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output cidh_pkg::rsp_t      out_rsp_o
);

  localparam int SW      = $clog2(TABLE_SLOTS);
  localparam int CW      = SW + 1;
  localparam int FULL_AT = TABLE_SLOTS * 3;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_CMP, B_OUT} bstate_e;

  logic [cidh_pkg::KEY_MEM_W-1:0] key_mem [TABLE_SLOTS];
  logic [cidh_pkg::VALUE_W-1:0]   val_mem [TABLE_SLOTS];
  logic [1:0]                     flag_mem [TABLE_SLOTS];

  logic [cidh_pkg::KEY_MEM_W-1:0] key_rd_q;
  logic [cidh_pkg::VALUE_W-1:0]   val_rd_q;
  logic [1:0]                     flag_rd_q;

  bstate_e        state_q;
  cidh_pkg::job_t job_q;
  cidh_pkg::rsp_t rsp_q;
  cidh_pkg::rsp_t rsp_d;
  logic           out_valid_q;
  logic [SW-1:0]  s_q;
  logic [SW-1:0]  probe_q;
  logic [SW-1:0]  free_q;
  logic           have_free_q;
  logic [SW-1:0]  clr_q;
  logic [CW-1:0]  count_q;

  logic           live, ever, match, end_miss, full;
  logic [SW-1:0]  free_slot;
  logic [CW+2:0]  load4;
  logic           finish, cnt_inc, cnt_dec;
  logic           flag_we, key_we, val_we;
  logic [SW-1:0]  flag_wa, key_wa, val_wa;
  logic [1:0]     flag_wd;

  assign live      = flag_rd_q[0];
  assign ever      = flag_rd_q[1];
  assign match     = live && (key_rd_q == {job_q.len, job_q.key2, job_q.key1, job_q.key0});
  assign end_miss  = !ever || (!match && probe_q == SW'(TABLE_SLOTS - 1));
  assign free_slot = have_free_q ? free_q : s_q;
  assign load4     = (CW+3)'({count_q, 2'b00}) + (CW+3)'(4);
  assign full      = int'(load4) >= FULL_AT;

  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign clearing_o  = (state_q == B_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  always_comb begin
    finish  = 1'b0;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    flag_we = 1'b0;
    key_we  = 1'b0;
    val_we  = 1'b0;
    flag_wa = s_q;
    key_wa  = free_slot;
    val_wa  = s_q;
    flag_wd = 2'b00;
    rsp_d   = '0;
    if (state_q == B_CLEAR) begin
      flag_we = 1'b1;
      flag_wa = clr_q;
    end else if (state_q == B_CMP) begin
      if (match) begin
        finish           = 1'b1;
        rsp_d.status     = cidh_pkg::ST_DONE;
        rsp_d.slot_index = 10'(s_q);
        case (job_q.mode)
          cidh_pkg::MODE_INSERT: begin
            val_we = 1'b1;
          end
          cidh_pkg::MODE_DELETE: begin
            flag_we = 1'b1;
            flag_wd = 2'b10;
            cnt_dec = (count_q != '0);
          end
          default: begin
            rsp_d.value_out = val_rd_q;
          end
        endcase
      end else if (end_miss) begin
        finish = 1'b1;
        if (job_q.mode == cidh_pkg::MODE_INSERT) begin
          if (full) begin
            rsp_d.status = cidh_pkg::ST_FULL;
          end else begin
            // new key goes to the first non-live slot seen on the chain
            flag_we          = 1'b1;
            flag_wa          = free_slot;
            flag_wd          = 2'b11;
            key_we           = 1'b1;
            val_we           = 1'b1;
            val_wa           = free_slot;
            cnt_inc          = 1'b1;
            rsp_d.status     = cidh_pkg::ST_DONE;
            rsp_d.slot_index = 10'(free_slot);
          end
        end else begin
          rsp_d.status = cidh_pkg::ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[s_q];
    val_rd_q  <= val_mem[s_q];
    flag_rd_q <= flag_mem[s_q];
    if (key_we) begin
      key_mem[key_wa] <= {job_q.len, job_q.key2, job_q.key1, job_q.key0};
    end
    if (val_we) begin
      val_mem[val_wa] <= job_q.handle;
    end
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      s_q         <= '0;
      job_q       <= '0;
      rsp_q       <= '0;
      probe_q     <= '0;
      free_q      <= '0;
      have_free_q <= 1'b0;
    end else begin
      if (cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == SW'(TABLE_SLOTS - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty_i) begin
            job_q       <= job_i;
            s_q         <= SW'(job_i.home);
            probe_q     <= '0;
            have_free_q <= 1'b0;
            if (job_i.bad) begin
              rsp_q       <= '{status: cidh_pkg::ST_BAD_LEN, value_out: '0, slot_index: '0};
              out_valid_q <= 1'b1;
              state_q     <= B_OUT;
            end else begin
              state_q <= B_READ;
            end
          end
        end
        B_READ: begin
          state_q <= B_CMP;
        end
        B_CMP: begin
          if (finish) begin
            rsp_q       <= rsp_d;
            out_valid_q <= 1'b1;
            state_q     <= B_OUT;
          end else begin
            if (!live && !have_free_q) begin
              free_q      <= s_q;
              have_free_q <= 1'b1;
            end
            s_q     <= s_q + SW'(1);
            probe_q <= probe_q + SW'(1);
            state_q <= B_READ;
          end
        end
        B_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/connection_id_hash_table.sv */
// top level of the connection id hash table: front end, job queue, back end
// depends on cidh_pkg, cidh_front, cidh_queue, cidh_back and the assertion header
//
// Usage: one request per transfer on the in channel (insert/replace, lookup or
// delete with a key of 1 to 20 bytes); exactly one response per request on the
// out channel, in request order. Both channels use valid/stall.
// Front end: it hashes one key byte per cycle and takes no new request until
// the current key is hashed and pushed into the queue; a request with a bad
// length skips the hashing and goes straight to the push.
// Back end: it picks up a job from the queue, then for each probed slot does a
// registered table read followed by a compare, and registers the result when
// the key matches or the chain ends. The queue lets the next key hash while the
// back end probes, so long chains only slow the input once the queue is full.
// Reset: after reset the back end clears the slot flags, one slot per cycle,
// through all TABLE_SLOTS slots, holding in_stall_o high until done.
// Stall: a result held by out_stall_i stays on out_rsp_o; the back end waits,
// and the front end keeps accepting until the queue fills.
`default_nettype none
`include "connection_id_hash_table_assert.svh"

module connection_id_hash_table #(
  parameter int TABLE_SLOTS = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire cidh_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output cidh_pkg::rsp_t      out_rsp_o
);

  cidh_pkg::job_t push_job;
  cidh_pkg::job_t head_job;
  logic           push, pop, q_full, q_empty, clearing;

  cidh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .hold_i     (clearing),
    .full_i     (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  cidh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cidh_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  `CIDH_ASSERT_IMP(a_no_overflow, push, !q_full, "push into full queue")
  `CIDH_ASSERT_IMP(a_stall_clear, clearing, in_stall_o, "request taken during flag clear")
  `CIDH_ASSERT_NXT(a_push_kept, push && !pop, !q_empty, "pushed job lost")
  `CIDH_ASSERT_IMP(a_bad_zero,
    out_valid_o && out_rsp_o.status == cidh_pkg::ST_BAD_LEN,
    out_rsp_o.value_out == '0 && out_rsp_o.slot_index == '0, "bad length with data")

endmodule

`default_nettype wire
